[hdl/hbdm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hbdm_pkg
// Shared types and codes for the host bus decoder and mailbox: payload
// structs, command and target codes, register offsets, control structs.
// ----------------------------------------------------------------------------
package hbdm_pkg;

  localparam logic [2:0] CMD_MEM_READ  = 3'd0;
  localparam logic [2:0] CMD_MEM_WRITE = 3'd1;
  localparam logic [2:0] CMD_IO_READ   = 3'd2;
  localparam logic [2:0] CMD_IO_WRITE  = 3'd3;
  localparam logic [2:0] CMD_STATUS    = 3'd4;

  localparam logic [1:0] TGT_NONE = 2'd0;
  localparam logic [1:0] TGT_BOOT = 2'd1;
  localparam logic [1:0] TGT_PRG  = 2'd2;
  localparam logic [1:0] TGT_WORD = 2'd3;

  // register window: 0xa120xx, bits 7..6 ignored
  localparam logic [15:0] REG_BASE = 16'ha120;

  localparam logic [5:0] OFS_IRQ     = 6'h00;
  localparam logic [5:0] OFS_RUN     = 6'h01;
  localparam logic [5:0] OFS_PROTECT = 6'h02;
  localparam logic [5:0] OFS_MEMMODE = 6'h03;
  localparam logic [5:0] OFS_VEC_HI  = 6'h06;
  localparam logic [5:0] OFS_VEC_LO  = 6'h07;
  localparam logic [5:0] OFS_TMR_HI  = 6'h0c;
  localparam logic [5:0] OFS_TMR_LO  = 6'h0d;
  localparam logic [5:0] OFS_MFLAGS  = 6'h0e;
  localparam logic [5:0] OFS_SFLAGS  = 6'h0f;

  localparam logic [1:0] BLK_CTRL   = 2'd0;
  localparam logic [1:0] BLK_CMD    = 2'd1;
  localparam logic [1:0] BLK_STATUS = 2'd2;

  typedef struct packed {
    logic [2:0]  cmd;
    logic        upper_lane;
    logic        lower_lane;
    logic [23:0] bus_address;
    logic [15:0] bus_data;
    logic        ram_mode;
    logic        ram_select;
    logic        ram_owned_by_sub;
    logic        irq_waiting;
    logic [11:0] timer_count;
    logic [7:0]  sub_flags;
  } item_t;

  typedef struct packed {
    logic [1:0]  target;
    logic [17:0] word_index;
    logic        is_store;
    logic        store_high;
    logic        store_low;
    logic [15:0] store_value;
    logic [15:0] read_value;
    logic        irq_raise;
    logic        sub_reset;
    logic        sub_halt;
    logic        switch_set;
  } result_t;

  typedef struct packed {
    logic load;
    logic step_hi;
    logic step_lo;
    logic cfg_we;
  } ctl_t;

  typedef struct packed {
    logic need_lower;
  } stat_t;

endpackage
`default_nettype wire

[hdl/hbdm_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hbdm_ctrl
// Sequencer: takes a beat, runs the upper lane step, the lower lane step
// when needed, then shows the result for one cycle.
// ----------------------------------------------------------------------------
module hbdm_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  output logic               done,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire hbdm_pkg::stat_t stat,
  output hbdm_pkg::ctl_t     ctl
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_HI   = 2'd1;
  localparam logic [1:0] S_LO   = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;

  assign busy      = (state == S_HI) || (state == S_LO);
  assign done      = (state == S_DONE);
  assign cfg_ready = (state == S_IDLE);
  assign accept    = start && !busy;

  assign ctl.load    = accept;
  assign ctl.step_hi = (state == S_HI);
  assign ctl.step_lo = (state == S_LO);
  assign ctl.cfg_we  = cfg_valid && cfg_ready;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) state_next = S_HI;
      end
      S_HI: begin
        state_next = stat.need_lower ? S_LO : S_DONE;
      end
      S_LO: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        state_next = accept ? S_HI : S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held longer than one cycle");

  a_accept_runs: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == S_HI))
    else $error("accepted beat not started");

  a_lo_after_hi: assert property (@(posedge clk) disable iff (rst)
    (state == S_LO) |-> ($past(state) == S_HI))
    else $error("lower lane step without upper lane step");

endmodule
`default_nettype wire

[hdl/hbdm_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hbdm_datapath
// Item register, memory decode, byte lane register file and result register.
// ----------------------------------------------------------------------------
module hbdm_datapath (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire hbdm_pkg::ctl_t   ctl,
  output hbdm_pkg::stat_t       stat,
  input  wire hbdm_pkg::item_t  item,
  input  wire logic [15:0]      cfg_data,
  output hbdm_pkg::result_t     result
);

  hbdm_pkg::item_t   item_q;
  hbdm_pkg::result_t res_q;
  hbdm_pkg::result_t res_next;

  logic [15:0] vector_word;
  logic [1:0]  bank_select;
  logic        run_bit;
  logic        request_bit;
  logic [7:0]  protect_byte;
  logic [7:0]  main_flags;
  logic [7:0]  command_bytes [16];
  logic [7:0]  status_bytes  [16];

  // memory decode
  logic        is_mem;
  logic [1:0]  mem_target;
  logic [17:0] mem_index;

  // lane access
  logic        lane_on;
  logic        lane_active;
  logic [5:0]  lane_ofs;
  logic        lane_hit;
  logic [7:0]  lane_d;
  logic [7:0]  lane_rd;
  logic        lane_we;
  logic        mode0_b0;
  logic        pulse_irq;
  logic        pulse_reset;
  logic        pulse_switch;

  assign stat.need_lower = (item_q.cmd == hbdm_pkg::CMD_IO_READ ||
                            item_q.cmd == hbdm_pkg::CMD_IO_WRITE) && item_q.lower_lane;

  always_comb begin
    is_mem     = (item_q.cmd == hbdm_pkg::CMD_MEM_READ) ||
                 (item_q.cmd == hbdm_pkg::CMD_MEM_WRITE);
    mem_target = hbdm_pkg::TGT_NONE;
    mem_index  = '0;
    if (!item_q.bus_address[21]) begin
      if (!item_q.bus_address[17]) begin
        if (item_q.cmd != hbdm_pkg::CMD_MEM_WRITE) begin
          mem_target = hbdm_pkg::TGT_BOOT;
          mem_index  = {2'b00, item_q.bus_address[16:1]};
        end
      end else begin
        mem_target = hbdm_pkg::TGT_PRG;
        mem_index  = {bank_select, item_q.bus_address[16:1]};
      end
    end else if (item_q.ram_mode) begin
      mem_target = hbdm_pkg::TGT_WORD;
      mem_index  = {1'b0, ~item_q.ram_select, item_q.bus_address[16:1]};
    end else if (!item_q.ram_owned_by_sub) begin
      mem_target = hbdm_pkg::TGT_WORD;
      mem_index  = {1'b0, item_q.bus_address[17:1]};
    end
  end

  assign lane_on     = ctl.step_hi || ctl.step_lo;
  assign lane_active = ctl.step_hi ? item_q.upper_lane : item_q.lower_lane;
  assign lane_ofs    = ctl.step_hi ? item_q.bus_address[5:0]
                                   : {item_q.bus_address[5:1], 1'b1};
  assign lane_hit    = (item_q.bus_address[23:8] == hbdm_pkg::REG_BASE);
  assign lane_d      = ctl.step_hi ? item_q.bus_data[15:8] : item_q.bus_data[7:0];
  assign mode0_b0    = item_q.ram_mode ? item_q.ram_select : ~item_q.ram_owned_by_sub;
  assign lane_we     = lane_on && lane_active && lane_hit &&
                       (item_q.cmd == hbdm_pkg::CMD_IO_WRITE);

  always_comb begin
    lane_rd = lane_d;
    if (lane_hit) begin
      case (lane_ofs[5:4])
        hbdm_pkg::BLK_CMD:    lane_rd = command_bytes[lane_ofs[3:0]];
        hbdm_pkg::BLK_STATUS: lane_rd = status_bytes[lane_ofs[3:0]];
        hbdm_pkg::BLK_CTRL: begin
          case (lane_ofs)
            hbdm_pkg::OFS_IRQ:     lane_rd = {lane_d[7:1], item_q.irq_waiting};
            hbdm_pkg::OFS_RUN:     lane_rd = {lane_d[7:2], request_bit, run_bit};
            hbdm_pkg::OFS_PROTECT: lane_rd = protect_byte;
            hbdm_pkg::OFS_MEMMODE: lane_rd = {bank_select, lane_d[5:3], item_q.ram_mode,
                                              item_q.ram_owned_by_sub, mode0_b0};
            hbdm_pkg::OFS_VEC_HI:  lane_rd = vector_word[15:8];
            hbdm_pkg::OFS_VEC_LO:  lane_rd = vector_word[7:0];
            hbdm_pkg::OFS_TMR_HI:  lane_rd = {lane_d[7:4], item_q.timer_count[11:8]};
            hbdm_pkg::OFS_TMR_LO:  lane_rd = item_q.timer_count[7:0];
            hbdm_pkg::OFS_MFLAGS:  lane_rd = main_flags;
            hbdm_pkg::OFS_SFLAGS:  lane_rd = item_q.sub_flags;
            default:               lane_rd = lane_d;
          endcase
        end
        default: lane_rd = lane_d;
      endcase
    end
  end

  assign pulse_irq    = lane_we && (lane_ofs == hbdm_pkg::OFS_IRQ) && lane_d[0];
  assign pulse_reset  = lane_we && (lane_ofs == hbdm_pkg::OFS_RUN) && run_bit && !lane_d[0];
  assign pulse_switch = lane_we && (lane_ofs == hbdm_pkg::OFS_MEMMODE) && lane_d[1];

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      item_q <= item;
    end
  end

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      vector_word  <= '0;
      bank_select  <= '0;
      run_bit      <= 1'b0;
      request_bit  <= 1'b0;
      protect_byte <= '0;
      main_flags   <= '0;
      for (int i = 0; i < 16; i++) begin
        command_bytes[i] <= '0;
        status_bytes[i]  <= '0;
      end
    end else begin
      if (ctl.cfg_we) begin
        vector_word <= cfg_data;
      end
      if (ctl.step_hi && item_q.cmd == hbdm_pkg::CMD_STATUS) begin
        status_bytes[item_q.bus_address[3:0]] <= item_q.bus_data[7:0];
      end
      if (lane_we) begin
        if (lane_ofs[5:4] == hbdm_pkg::BLK_CMD) begin
          command_bytes[lane_ofs[3:0]] <= lane_d;
        end
        case (lane_ofs)
          hbdm_pkg::OFS_RUN: begin
            run_bit     <= lane_d[0];
            request_bit <= lane_d[1];
          end
          hbdm_pkg::OFS_PROTECT: protect_byte <= lane_d;
          hbdm_pkg::OFS_MEMMODE: bank_select <= lane_d[7:6];
          hbdm_pkg::OFS_VEC_HI:  vector_word[15:8] <= lane_d;
          hbdm_pkg::OFS_VEC_LO:  vector_word[7:0] <= lane_d;
          hbdm_pkg::OFS_MFLAGS:  main_flags <= lane_d;
          default: begin
          end
        endcase
      end
    end
  end

  // result register
  always_comb begin
    res_next = res_q;
    if (ctl.step_hi) begin
      res_next            = '0;
      res_next.irq_raise  = pulse_irq;
      res_next.sub_reset  = pulse_reset;
      res_next.switch_set = pulse_switch;
      if (is_mem) begin
        res_next.target     = mem_target;
        res_next.word_index = mem_index;
        if (item_q.cmd == hbdm_pkg::CMD_MEM_WRITE && mem_target != hbdm_pkg::TGT_NONE) begin
          res_next.is_store    = 1'b1;
          res_next.store_high  = item_q.upper_lane;
          res_next.store_low   = item_q.lower_lane;
          res_next.store_value = item_q.bus_data;
        end
        if (item_q.cmd == hbdm_pkg::CMD_MEM_READ && mem_target == hbdm_pkg::TGT_NONE) begin
          res_next.read_value = item_q.bus_data;
        end
      end
      if (item_q.cmd == hbdm_pkg::CMD_IO_READ) begin
        res_next.read_value = {(item_q.upper_lane ? lane_rd : item_q.bus_data[15:8]),
                               item_q.bus_data[7:0]};
      end
    end else if (ctl.step_lo) begin
      if (item_q.cmd == hbdm_pkg::CMD_IO_READ) begin
        res_next.read_value[7:0] = lane_rd;
      end
      res_next.irq_raise  = res_q.irq_raise | pulse_irq;
      res_next.sub_reset  = res_q.sub_reset | pulse_reset;
      res_next.switch_set = res_q.switch_set | pulse_switch;
    end
  end

  always_ff @(posedge clk) begin
    res_q <= res_next;
  end

  always_comb begin
    result          = res_q;
    result.sub_halt = !run_bit || request_bit;
  end

  a_lo_io_only: assert property (@(posedge clk) disable iff (rst)
    ctl.step_lo |-> ((item_q.cmd == hbdm_pkg::CMD_IO_READ ||
                      item_q.cmd == hbdm_pkg::CMD_IO_WRITE) && item_q.lower_lane))
    else $error("lower lane step on a beat without an active lower io lane");

  a_cfg_not_mid_item: assert property (@(posedge clk) disable iff (rst)
    ctl.cfg_we |-> !(ctl.step_hi || ctl.step_lo))
    else $error("vector load during a lane step");

endmodule
`default_nettype wire

[hdl/host_bus_decoder_and_mailbox.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// host_bus_decoder_and_mailbox
// Host bus decode into boot ROM, program RAM and word RAM words, plus a byte
// register mailbox with interrupt, sub reset and switch pulses.
//
//   channel   handshake            payload             dir
//   item      start / busy         item   (item_t)     in
//   result    done (strobe)        result (result_t)   out
//   config    cfg_valid/cfg_ready  cfg_data [15:0]     in
//
// A beat runs the upper lane step, the lower lane step when an io beat has
// its lower lane active, and then the result cycle: the register file does
// one lane per cycle. busy is low during the result cycle so the next beat
// enters then. done is high for exactly one cycle; the receiver cannot stall it.
// Synchronous active-high reset clears the state and mailbox registers (vector word to 0), not item/result.
// cfg_ready is high only while no beat is in flight.
// ----------------------------------------------------------------------------
module host_bus_decoder_and_mailbox (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire hbdm_pkg::item_t   item,
  output logic                   done,
  output hbdm_pkg::result_t      result,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [15:0]       cfg_data
);

  hbdm_pkg::ctl_t  ctl;
  hbdm_pkg::stat_t stat;

  hbdm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  hbdm_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .stat     (stat),
    .item     (item),
    .cfg_data (cfg_data),
    .result   (result)
  );

endmodule
`default_nettype wire
